FILE: hdl/bqcc_pkg.sv
// bqcc_pkg: types, character codes and helper functions for the bracket checker
// no dependencies; imported by the stack, scanner and top-level modules
`timescale 1ns / 1ps
`default_nettype none

package bqcc_pkg;

    // scanner mode
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_QUOTE   = 2'd1,
        MODE_COMMENT = 2'd2
    } t_mode;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MISMATCH    = 3'd1,
        ST_EMPTY_CLOSE = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_UNCLOSED    = 3'd4
    } t_status;

    // bracket kind as kept on the stack
    typedef logic [1:0] t_code;
    localparam t_code CODE_PAREN   = 2'd0;
    localparam t_code CODE_BRACE   = 2'd1;
    localparam t_code CODE_BRACKET = 2'd2;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NONE    = 8'h00;

    localparam logic [15:0] LINE_MAX   = 16'hFFFF;
    localparam logic [15:0] LINE_FIRST = 16'd1;

    // push/pop request from the scanner to the stack
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        t_code code;
    } t_stack_cmd;

    // stack view seen by the scanner
    typedef struct packed {
        logic  empty;
        logic  full;
        logic  two_plus;
        t_code top;
        t_code below;
    } t_stack_stat;

    // one result item
    typedef struct packed {
        t_status     status;
        logic [15:0] line_no;
        logic [7:0]  open_char;
        logic [7:0]  close_char;
        logic        done_res;
    } t_result;

    function automatic logic [7:0] open_char_of(input t_code code);
        logic [7:0] c;
        case (code)
            CODE_BRACE:   c = CH_LBRACE;
            CODE_BRACKET: c = CH_LBRACK;
            default:      c = CH_LPAREN;
        endcase
        return c;
    endfunction

    // works for both openers and closers
    function automatic t_code code_of(input logic [7:0] c);
        t_code code;
        if (c == CH_LPAREN || c == CH_RPAREN) begin
            code = CODE_PAREN;
        end else if (c == CH_LBRACE || c == CH_RBRACE) begin
            code = CODE_BRACE;
        end else begin
            code = CODE_BRACKET;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bqcc_in_if.sv
// bqcc_in_if: input channel, one text character per transfer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bqcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bqcc_out_if.sv
// bqcc_out_if: result channel, one verdict or running status per transfer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bqcc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] line_no;
    logic [7:0]  open_char;
    logic [7:0]  close_char;
    logic        done_res;

    modport source (
        output valid, output status, output line_no, output open_char,
        output close_char, output done_res, input ready
    );
    modport sink (
        input valid, input status, input line_no, input open_char,
        input close_char, input done_res, output ready
    );
endinterface

`default_nettype wire

FILE: hdl/bqcc_stack.sv
// bqcc_stack: bracket stack with top and next-below cached in registers
// depends on bqcc_pkg; the body of the stack lives in a memory with registered read
`timescale 1ns / 1ps
`default_nettype none

module bqcc_stack #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bqcc_pkg::t_stack_cmd i_cmd,
    output bqcc_pkg::t_stack_stat   o_stat
);
    import bqcc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    t_code          mem [STACK_DEPTH];
    logic [DW-1:0]  r_depth;
    logic [DW-1:0]  n_depth;
    logic [DW-1:0]  rd_sum;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    t_code          r_top;
    t_code          n_top;
    t_code          r_below;
    t_code          n_below;
    t_code          r_rd;

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        n_below = r_below;
        if (i_cmd.clear) begin
            n_depth = '0;
        end else if (i_cmd.push) begin
            n_depth = r_depth + DW'(1);
            n_top   = i_cmd.code;
            n_below = r_top;
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DW'(1);
            n_top   = r_below;
            n_below = r_rd;
        end
    end

    // prefetch the entry two under the new top, for a pop on the next transfer
    assign rd_sum  = n_depth - DW'(3);
    assign rd_addr = rd_sum[AW-1:0];
    assign wr_addr = r_depth[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            mem[wr_addr] <= i_cmd.code;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top   <= n_top;
        r_below <= n_below;
    end

    assign o_stat.empty    = (r_depth == '0);
    assign o_stat.full     = (r_depth == DW'(STACK_DEPTH));
    assign o_stat.two_plus = (r_depth >= DW'(2));
    assign o_stat.top      = r_top;
    assign o_stat.below    = r_below;

endmodule

`default_nettype wire

FILE: hdl/bqcc_scan.sv
// bqcc_scan: character scanner, line counter and sticky error record
// depends on bqcc_pkg; drives push/pop requests into bqcc_stack
`timescale 1ns / 1ps
`default_nettype none

module bqcc_scan (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_ch,
    input  wire logic                  i_last,
    input  wire bqcc_pkg::t_stack_stat i_stat,
    output bqcc_pkg::t_stack_cmd       o_cmd,
    output bqcc_pkg::t_result          o_result
);
    import bqcc_pkg::*;

    t_mode       r_mode, n_mode;
    logic        r_qkind, n_qkind;
    logic        r_bslash, n_bslash;
    logic        r_slash, n_slash;
    logic        r_star, n_star;
    logic [15:0] r_line, n_line;
    t_status     r_err_status, n_err_status;
    logic [15:0] r_err_line, n_err_line;
    logic [7:0]  r_err_open, n_err_open;
    logic [7:0]  r_err_close, n_err_close;

    logic        is_opener, is_closer, is_quote;
    logic        scan_en;
    logic        raise;
    t_status     raise_status;
    logic [7:0]  raise_open, raise_close;
    t_stack_cmd  cmd;
    logic        post_nonempty;
    t_code       post_top;
    logic [7:0]  quote_ch;

    assign is_opener = (i_ch == CH_LPAREN) || (i_ch == CH_LBRACE) || (i_ch == CH_LBRACK);
    assign is_closer = (i_ch == CH_RPAREN) || (i_ch == CH_RBRACE) || (i_ch == CH_RBRACK);
    assign is_quote  = (i_ch == CH_SQUOTE) || (i_ch == CH_DQUOTE);
    assign scan_en   = (r_err_status == ST_OK);
    assign quote_ch  = r_qkind ? CH_DQUOTE : CH_SQUOTE;

    // mode next state
    always_comb begin
        n_mode   = r_mode;
        n_qkind  = r_qkind;
        n_bslash = r_bslash;
        n_slash  = r_slash;
        n_star   = r_star;
        if (scan_en) begin
            case (r_mode)
                MODE_NORMAL: begin
                    n_slash = 1'b0;
                    if (is_opener || is_closer) begin
                        n_mode = MODE_NORMAL;
                    end else if (is_quote) begin
                        n_mode   = MODE_QUOTE;
                        n_qkind  = (i_ch == CH_DQUOTE);
                        n_bslash = 1'b0;
                    end else if (i_ch == CH_STAR && r_slash) begin
                        n_mode = MODE_COMMENT;
                        n_star = 1'b0;
                    end else if (i_ch == CH_SLASH) begin
                        n_slash = 1'b1;
                    end
                end
                MODE_QUOTE: begin
                    if (r_bslash) begin
                        n_bslash = 1'b0;
                    end else if (i_ch == CH_BSLASH) begin
                        n_bslash = 1'b1;
                    end else if (i_ch == quote_ch) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_COMMENT: begin
                    if (i_ch == CH_SLASH && r_star) begin
                        n_mode = MODE_NORMAL;
                        n_star = 1'b0;
                    end else begin
                        n_star = (i_ch == CH_STAR);
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                end
            endcase
        end
        // end of text returns the scanner to its reset state
        if (i_last) begin
            n_mode   = MODE_NORMAL;
            n_qkind  = 1'b0;
            n_bslash = 1'b0;
            n_slash  = 1'b0;
            n_star   = 1'b0;
        end
    end

    // stack requests, errors, result
    always_comb begin
        n_line = (i_ch == CH_NEWLINE && r_line != LINE_MAX) ? r_line + 16'd1 : r_line;

        cmd          = '0;
        cmd.code     = code_of(i_ch);
        raise        = 1'b0;
        raise_status = ST_OK;
        raise_open   = CH_NONE;
        raise_close  = CH_NONE;

        if (scan_en && r_mode == MODE_NORMAL) begin
            if (is_opener) begin
                if (i_stat.full) begin
                    raise        = 1'b1;
                    raise_status = ST_OVERFLOW;
                    raise_open   = i_ch;
                end else begin
                    cmd.push = 1'b1;
                end
            end else if (is_closer) begin
                if (i_stat.empty) begin
                    raise        = 1'b1;
                    raise_status = ST_EMPTY_CLOSE;
                    raise_close  = i_ch;
                end else if (i_stat.top == cmd.code) begin
                    cmd.pop = 1'b1;
                end else begin
                    raise        = 1'b1;
                    raise_status = ST_MISMATCH;
                    raise_open   = open_char_of(i_stat.top);
                    raise_close  = i_ch;
                end
            end
        end

        // unclosed check on the final character, against the stack after this step
        post_nonempty = cmd.push || (cmd.pop ? i_stat.two_plus : !i_stat.empty);
        post_top      = cmd.push ? cmd.code : (cmd.pop ? i_stat.below : i_stat.top);
        if (i_last && scan_en && !raise) begin
            if (post_nonempty) begin
                raise        = 1'b1;
                raise_status = ST_UNCLOSED;
                raise_open   = open_char_of(post_top);
            end else if (n_mode_pre_is(MODE_QUOTE)) begin
                raise        = 1'b1;
                raise_status = ST_UNCLOSED;
                raise_open   = qkind_pre() ? CH_DQUOTE : CH_SQUOTE;
            end else if (n_mode_pre_is(MODE_COMMENT)) begin
                raise        = 1'b1;
                raise_status = ST_UNCLOSED;
                raise_open   = CH_SLASH;
            end
        end

        n_err_status = r_err_status;
        n_err_line   = r_err_line;
        n_err_open   = r_err_open;
        n_err_close  = r_err_close;
        if (raise) begin
            n_err_status = raise_status;
            n_err_line   = n_line;
            n_err_open   = raise_open;
            n_err_close  = raise_close;
        end

        if (n_err_status != ST_OK) begin
            o_result.status     = n_err_status;
            o_result.line_no    = n_err_line;
            o_result.open_char  = n_err_open;
            o_result.close_char = n_err_close;
        end else begin
            o_result.status     = ST_OK;
            o_result.line_no    = n_line;
            o_result.open_char  = CH_NONE;
            o_result.close_char = CH_NONE;
        end
        o_result.done_res = i_last;

        if (i_last) begin
            cmd.clear    = 1'b1;
            n_line       = LINE_FIRST;
            n_err_status = ST_OK;
            n_err_line   = '0;
            n_err_open   = CH_NONE;
            n_err_close  = CH_NONE;
        end
    end

    // mode and quote kind after this character, before the end-of-text clear
    function automatic logic n_mode_pre_is(input t_mode m);
        logic hit;
        hit = 1'b0;
        case (r_mode)
            MODE_NORMAL: begin
                if (is_quote && !is_opener && !is_closer) begin
                    hit = (m == MODE_QUOTE);
                end else if (i_ch == CH_STAR && r_slash) begin
                    hit = (m == MODE_COMMENT);
                end else begin
                    hit = (m == MODE_NORMAL);
                end
            end
            MODE_QUOTE: begin
                if (!r_bslash && i_ch != CH_BSLASH && i_ch == quote_ch) begin
                    hit = (m == MODE_NORMAL);
                end else begin
                    hit = (m == MODE_QUOTE);
                end
            end
            MODE_COMMENT: begin
                if (i_ch == CH_SLASH && r_star) begin
                    hit = (m == MODE_NORMAL);
                end else begin
                    hit = (m == MODE_COMMENT);
                end
            end
            default: begin
                hit = (m == MODE_NORMAL);
            end
        endcase
        return hit;
    endfunction

    function automatic logic qkind_pre();
        logic q;
        q = r_qkind;
        if (r_mode == MODE_NORMAL && is_quote) begin
            q = (i_ch == CH_DQUOTE);
        end
        return q;
    endfunction

    assign o_cmd.push  = cmd.push && i_accept;
    assign o_cmd.pop   = cmd.pop && i_accept;
    assign o_cmd.clear = cmd.clear && i_accept;
    assign o_cmd.code  = cmd.code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_qkind      <= 1'b0;
            r_bslash     <= 1'b0;
            r_slash      <= 1'b0;
            r_star       <= 1'b0;
            r_line       <= LINE_FIRST;
            r_err_status <= ST_OK;
            r_err_line   <= '0;
            r_err_open   <= CH_NONE;
            r_err_close  <= CH_NONE;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_qkind      <= n_qkind;
            r_bslash     <= n_bslash;
            r_slash      <= n_slash;
            r_star       <= n_star;
            r_line       <= n_line;
            r_err_status <= n_err_status;
            r_err_line   <= n_err_line;
            r_err_open   <= n_err_open;
            r_err_close  <= n_err_close;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bracket_quote_comment_checker_unit.sv
// the result of each accepted character is captured in the output register
// throughput: 1 character per cycle unless the output stalls; the stack keeps its top two
// in registers, prefetching the third every cycle from a one-write, one-read-port memory
// reset: synchronous active-low i_rst_n clears mode, line count, error record,
// stack depth and output valid; stack memory contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module bracket_quote_comment_checker_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bqcc_in_if.sink      i_in,
    bqcc_out_if.source   o_out
);
    import bqcc_pkg::*;

    // handshake
    logic        accept;
    logic        r_out_valid;
    t_result     r_out;

    // scanner to stack and back
    t_stack_cmd  stack_cmd;
    t_stack_stat stack_stat;
    t_result     scan_result;

    // output register frees itself when the sink takes the transfer
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // bracket stack: depth counter, cached top/below, memory body
    bqcc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stack_cmd),
        .o_stat  (stack_stat)
    );

    // per-character scan, line count and sticky error
    bqcc_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_in.ch),
        .i_last   (i_in.last),
        .i_stat   (stack_stat),
        .o_cmd    (stack_cmd),
        .o_result (scan_result)
    );

    // result register, payload without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= scan_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.line_no    = r_out.line_no;
    assign o_out.open_char  = r_out.open_char;
    assign o_out.close_char = r_out.close_char;
    assign o_out.done_res   = r_out.done_res;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for bracket_quote_comment_checker_unit
// drives text into bqcc_in_if, checks every bqcc_out_if result against the scan model or script
// depends on bqcc_pkg, bqcc_in_if, bqcc_out_if and the checker rtl
`timescale 1ns / 1ps

module tb_top;
    import bqcc_pkg::*;

    localparam int DEPTH       = 256;      // stack entries of the instance under test
    localparam int ITEM_TARGET = 1700;     // rough target of characters sent over the whole run
    localparam int TAIL_ITEMS  = 250;      // rough size of the closing full-rate stretch
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;
    localparam int ROWS        = 25;

    // one line of the directed script
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;   // want is written out by hand
        t_result    want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bqcc_in_if  in_ch ();
    bqcc_out_if out_ch ();

    bracket_quote_comment_checker_unit #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // scan model: bracket stack, literal / comment tracking, sticky error
    // ------------------------------------------------------------------
    t_code       nest_stack [DEPTH];
    int unsigned nest_depth;
    t_mode       scan_mode;
    logic        dq_kind;       // open literal uses double quotes
    logic        esc_pending;   // backslash seen inside a literal
    logic        slash_seen;    // '/' just seen in plain text
    logic        star_seen;     // '*' just seen inside a comment
    logic [15:0] line_cnt;
    t_status     err_st;
    logic [15:0] err_ln;
    logic [7:0]  err_open;
    logic [7:0]  err_close;

    t_result     verdict_q [$];   // results still owed by the unit
    logic [7:0]  text_buf [$];    // text being built for the next send
    t_row        script [ROWS];

    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  counted_items = 0;       // characters transferred so far
    int  calm_left    = 0;
    bit  traffic_gaps = 1'b1;     // random idling on both channels

    function automatic t_code bracket_kind(input logic [7:0] c);
        case (c)
            CH_LPAREN, CH_RPAREN: return CODE_PAREN;
            CH_LBRACE, CH_RBRACE: return CODE_BRACE;
            default:              return CODE_BRACKET;
        endcase
    endfunction

    function automatic logic [7:0] opener_glyph(input t_code k);
        case (k)
            CODE_PAREN: return CH_LPAREN;
            CODE_BRACE: return CH_LBRACE;
            default:    return CH_LBRACK;
        endcase
    endfunction

    function automatic logic [7:0] closer_glyph(input t_code k);
        case (k)
            CODE_PAREN: return CH_RPAREN;
            CODE_BRACE: return CH_RBRACE;
            default:    return CH_RBRACK;
        endcase
    endfunction

    // back to the state right after reset, also used after each end of text
    function automatic void restart_scan();
        nest_depth  = 0;
        scan_mode   = MODE_NORMAL;
        dq_kind     = 1'b0;
        esc_pending = 1'b0;
        slash_seen  = 1'b0;
        star_seen   = 1'b0;
        line_cnt    = LINE_FIRST;
        err_st      = ST_OK;
        err_ln      = '0;
        err_open    = CH_NONE;
        err_close   = CH_NONE;
    endfunction

    function automatic void flag_error(input t_status s, input logic [7:0] oc,
                                       input logic [7:0] cc);
        err_st    = s;
        err_ln    = line_cnt;
        err_open  = oc;
        err_close = cc;
    endfunction

    // advance the model by one character and return the result it owes
    function automatic t_result predict_verdict(input logic [7:0] c, input logic lst);
        t_result r;
        t_code   k;
        logic    was_slash;
        logic [7:0] q;
        // newlines count in every mode, error or not
        if (c == CH_NEWLINE && line_cnt != LINE_MAX) line_cnt++;
        if (err_st == ST_OK) begin
            case (scan_mode)
                MODE_NORMAL: begin
                    was_slash  = slash_seen;
                    slash_seen = 1'b0;
                    if (c == CH_LPAREN || c == CH_LBRACE || c == CH_LBRACK) begin
                        k = bracket_kind(c);
                        if (nest_depth >= DEPTH) begin
                            flag_error(ST_OVERFLOW, c, CH_NONE);
                        end else begin
                            nest_stack[nest_depth] = k;
                            nest_depth++;
                        end
                    end else if (c == CH_RPAREN || c == CH_RBRACE || c == CH_RBRACK) begin
                        k = bracket_kind(c);
                        if (nest_depth == 0) begin
                            flag_error(ST_EMPTY_CLOSE, CH_NONE, c);
                        end else if (nest_stack[nest_depth - 1] == k) begin
                            nest_depth--;
                        end else begin
                            // wrong closer leaves the opener on the stack
                            flag_error(ST_MISMATCH, opener_glyph(nest_stack[nest_depth - 1]), c);
                        end
                    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                        scan_mode   = MODE_QUOTE;
                        dq_kind     = (c == CH_DQUOTE);
                        esc_pending = 1'b0;
                    end else if (c == CH_STAR && was_slash) begin
                        scan_mode = MODE_COMMENT;
                        star_seen = 1'b0;   // opener star never closes
                    end else if (c == CH_SLASH) begin
                        slash_seen = 1'b1;
                    end
                end
                MODE_QUOTE: begin
                    q = dq_kind ? CH_DQUOTE : CH_SQUOTE;
                    if (esc_pending) begin
                        esc_pending = 1'b0;
                    end else if (c == CH_BSLASH) begin
                        esc_pending = 1'b1;
                    end else if (c == q) begin
                        scan_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if (c == CH_SLASH && star_seen) begin
                        scan_mode = MODE_NORMAL;
                        star_seen = 1'b0;
                    end else begin
                        star_seen = (c == CH_STAR);
                    end
                end
            endcase
        end
        // end-of-text verdict: innermost bracket first, then literal, then comment
        if (lst && err_st == ST_OK) begin
            if (nest_depth > 0) begin
                flag_error(ST_UNCLOSED, opener_glyph(nest_stack[nest_depth - 1]), CH_NONE);
            end else if (scan_mode == MODE_QUOTE) begin
                flag_error(ST_UNCLOSED, dq_kind ? CH_DQUOTE : CH_SQUOTE, CH_NONE);
            end else if (scan_mode == MODE_COMMENT) begin
                flag_error(ST_UNCLOSED, CH_SLASH, CH_NONE);
            end
        end
        if (err_st != ST_OK) begin
            r.status     = err_st;
            r.line_no    = err_ln;
            r.open_char  = err_open;
            r.close_char = err_close;
        end else begin
            r.status     = ST_OK;
            r.line_no    = line_cnt;
            r.open_char  = CH_NONE;
            r.close_char = CH_NONE;
        end
        r.done_res = lst;
        if (lst) restart_scan();
        return r;
    endfunction

    function automatic t_row mk_row(input logic [7:0] c, input logic l, input logic typed,
                                    input t_status s, input logic [15:0] ln,
                                    input logic [7:0] oc, input logic [7:0] cc);
        t_row r;
        r.ch              = c;
        r.last            = l;
        r.typed           = typed;
        r.want.status     = s;
        r.want.line_no    = ln;
        r.want.open_char  = oc;
        r.want.close_char = cc;
        r.want.done_res   = l;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
                   c == CH_LBRACK || c == CH_RBRACK || c == CH_SQUOTE || c == CH_DQUOTE ||
                   c == CH_SLASH || c == CH_STAR || c == CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] markup_char();
        case ($urandom_range(0, 11))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_LBRACK;
            5:       return CH_RBRACK;
            6:       return CH_SQUOTE;
            7:       return CH_DQUOTE;
            8:       return CH_BSLASH;
            9:       return CH_SLASH;
            10:      return CH_STAR;
            default: return CH_NEWLINE;
        endcase
    endfunction

    // quoted literal with escapes, closed properly
    function automatic void add_literal();
        logic [7:0] q;
        logic [7:0] c;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        text_buf.push_back(q);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
                0: begin
                    text_buf.push_back(CH_BSLASH);
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    // escaped quote must not end the literal
                    text_buf.push_back(CH_BSLASH);
                    text_buf.push_back(q);
                end
                2: text_buf.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                3: begin
                    c = markup_char();
                    if (c == q || c == CH_BSLASH) text_buf.push_back(CH_BSLASH);
                    text_buf.push_back(c);
                end
                default: text_buf.push_back(plain_char());
            endcase
        end
        text_buf.push_back(q);
    endfunction

    // block comment, body never holds star-slash
    function automatic void add_comment();
        logic [7:0] c;
        logic       prev_star;
        text_buf.push_back(CH_SLASH);
        text_buf.push_back(CH_STAR);
        prev_star = 1'b0;   // lets a slash right after the opener through
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 3))
                0:       c = CH_STAR;
                1:       c = CH_SLASH;
                2:       c = markup_char();
                default: c = plain_char();
            endcase
            if (prev_star && c == CH_SLASH) c = plain_char();
            text_buf.push_back(c);
            prev_star = (c == CH_STAR);
        end
        text_buf.push_back(CH_STAR);
        text_buf.push_back(CH_SLASH);
    endfunction

    // well-formed text: nested brackets, literals, comments, lone slashes
    function automatic void build_balanced(input int steps);
        t_code open_kinds [$];
        t_code k;
        text_buf.delete();
        for (int s = 0; s < steps; s++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if (open_kinds.size() < 12) begin
                        k = t_code'($urandom_range(0, 2));
                        open_kinds.push_back(k);
                        text_buf.push_back(opener_glyph(k));
                    end
                end
                2, 3: begin
                    if (open_kinds.size() > 0) text_buf.push_back(closer_glyph(open_kinds.pop_back()));
                end
                4: add_literal();
                5: add_comment();
                6: text_buf.push_back(CH_NEWLINE);
                7: begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(plain_char());
                end
                default: text_buf.push_back(plain_char());
            endcase
        end
        while (open_kinds.size() > 0) text_buf.push_back(closer_glyph(open_kinds.pop_back()));
        if (text_buf.size() == 0) text_buf.push_back(plain_char());
    endfunction

    // deep nesting: full stack, overflow or unclosed at depth
    function automatic void build_deep(input int opens, input bit close_all);
        t_code open_kinds [$];
        t_code k;
        text_buf.delete();
        repeat (opens) begin
            k = t_code'($urandom_range(0, 2));
            open_kinds.push_back(k);
            text_buf.push_back(opener_glyph(k));
        end
        if (close_all) begin
            while (open_kinds.size() > 0) text_buf.push_back(closer_glyph(open_kinds.pop_back()));
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic lst, input logic typed,
                             input t_result want);
        t_result guess;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 120);
        end else if (traffic_gaps && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        in_ch.last  <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        // transfer taken at this edge
        counted_items++;
        guess = predict_verdict(c, lst);
        verdict_q.push_back(typed ? want : guess);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
    endtask

    // hold the input off until the unit owes nothing
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, plus long stretches without any
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 12))
                @(posedge i_clk);
            if (traffic_gaps && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status     = t_status'(out_ch.status);
            got.line_no    = out_ch.line_no;
            got.open_char  = out_ch.open_char;
            got.close_char = out_ch.close_char;
            got.done_res   = out_ch.done_res;
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("result with none owed: status %0d line %0d open %h close %h done %b",
                             got.status, got.line_no, got.open_char, got.close_char, got.done_res);
            end else begin
                want = verdict_q.pop_front();
                if (got.status !== want.status || got.line_no !== want.line_no ||
                    got.open_char !== want.open_char || got.close_char !== want.close_char ||
                    got.done_res !== want.done_res) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"result mismatch: expected status %0d line %0d open %h close %h",
                                  " done %b, got status %0d line %0d open %h close %h done %b"},
                                 want.status, want.line_no, want.open_char, want.close_char,
                                 want.done_res, got.status, got.line_no, got.open_char,
                                 got.close_char, got.done_res);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bracket_quote_comment_checker_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int  pick;
        bit  paused_once;
        paused_once = 1'b0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.ch    <= CH_NONE;
        in_ch.last  <= 1'b0;
        restart_scan();

        // directed script; hand-written results where they are obvious
        script[0]  = mk_row(8'h00,     1'b0, 1'b1, ST_OK,          16'd1, CH_NONE,   CH_NONE);
        script[1]  = mk_row(CH_NEWLINE, 1'b0, 1'b1, ST_OK,         16'd2, CH_NONE,   CH_NONE);
        // closer with nothing open
        script[2]  = mk_row(CH_RPAREN, 1'b0, 1'b1, ST_EMPTY_CLOSE, 16'd2, CH_NONE,   CH_RPAREN);
        // error line stays put while newlines keep counting
        script[3]  = mk_row(CH_NEWLINE, 1'b1, 1'b1, ST_EMPTY_CLOSE, 16'd2, CH_NONE,  CH_RPAREN);
        script[4]  = mk_row(CH_LPAREN, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[5]  = mk_row(CH_LBRACK, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[6]  = mk_row(CH_LBRACE, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[7]  = mk_row(CH_RBRACE, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[8]  = mk_row(CH_RBRACK, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[9]  = mk_row(CH_RPAREN, 1'b1, 1'b1, ST_OK,          16'd1, CH_NONE,   CH_NONE);
        // wrong closer
        script[10] = mk_row(CH_LPAREN, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[11] = mk_row(CH_RBRACK, 1'b0, 1'b1, ST_MISMATCH,    16'd1, CH_LPAREN, CH_RBRACK);
        script[12] = mk_row(8'hFF,     1'b1, 1'b1, ST_MISMATCH,    16'd1, CH_LPAREN, CH_RBRACK);
        // escaped quote, then escaped backslash before the real closing quote
        script[13] = mk_row(CH_DQUOTE, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[14] = mk_row(CH_BSLASH, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[15] = mk_row(CH_DQUOTE, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[16] = mk_row(CH_BSLASH, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[17] = mk_row(CH_BSLASH, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[18] = mk_row(CH_DQUOTE, 1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[19] = mk_row(8'hFF,     1'b1, 1'b1, ST_OK,          16'd1, CH_NONE,   CH_NONE);
        // slash-star-slash leaves the comment open
        script[20] = mk_row(CH_SLASH,  1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[21] = mk_row(CH_STAR,   1'b0, 1'b0, ST_OK,          '0,    CH_NONE,   CH_NONE);
        script[22] = mk_row(CH_SLASH,  1'b1, 1'b1, ST_UNCLOSED,    16'd1, CH_SLASH,  CH_NONE);
        // open literal and open bracket at the end
        script[23] = mk_row(CH_SQUOTE, 1'b1, 1'b1, ST_UNCLOSED,    16'd1, CH_SQUOTE, CH_NONE);
        script[24] = mk_row(CH_LBRACE, 1'b1, 1'b1, ST_UNCLOSED,    16'd1, CH_LBRACE, CH_NONE);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send_char(script[i].ch, script[i].last, script[i].typed, script[i].want);
        wait_drained();

        // stack at its limits: full and emptied, overflow, unclosed one short of full
        build_deep(DEPTH, 1'b1);
        send_text();
        build_deep(DEPTH + 1, 1'b0);
        send_text();
        build_deep(DEPTH - 1, 1'b0);
        send_text();

        // random texts, mostly well formed
        while (counted_items < ITEM_TARGET - TAIL_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                build_balanced($urandom_range(1, 30));
            end else if (pick < 16) begin
                // broken text: one character swapped for markup, or the tail cut off
                build_balanced($urandom_range(2, 30));
                if ($urandom_range(0, 1)) begin
                    text_buf[$urandom_range(0, text_buf.size() - 1)] = markup_char();
                end else begin
                    repeat ($urandom_range(1, 3)) if (text_buf.size() > 1) void'(text_buf.pop_back());
                end
            end else begin
                text_buf.delete();
                repeat ($urandom_range(1, 30))
                    text_buf.push_back($urandom_range(0, 1) ? markup_char()
                                                            : 8'($urandom_range(0, 255)));
            end
            send_text();
            if (!paused_once && counted_items >= ITEM_TARGET / 2) begin
                paused_once = 1'b1;
                wait_drained();
            end
        end

        // closing stretch at full rate
        traffic_gaps = 1'b0;
        repeat (5) begin
            build_balanced($urandom_range(10, 30));
            send_text();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bracket_quote_comment_checker_unit test passed");
        end else begin
            $display("bracket_quote_comment_checker_unit test failed");
        end
        $finish;
    end

endmodule

FILE: bracket_quote_comment_checker_unit.f
hdl/bqcc_pkg.sv
hdl/bqcc_in_if.sv
hdl/bqcc_out_if.sv
hdl/bqcc_stack.sv
hdl/bqcc_scan.sv
hdl/bracket_quote_comment_checker_unit.sv
tb/tb_top.sv
